@@ src/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants for the string escape decoder
// Mode and result codes, character constants and digit decode helpers.
// ----------------------------------------------------------------------------
package sed_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_ESCAPE = 3'd2,
        MODE_OCTAL  = 3'd3,
        MODE_HEX    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_CLOSED  = 2'd1,
        KIND_UNTERM  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } t_kind;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_UP_X   = 8'h58;

    // decoder state carried from one item to the next
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  esc_val;
        logic [1:0]  oct_cnt;
    } t_state;

    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
    } t_res;

    // results caused by one item: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0]  count;
        t_res        first;
        t_res        second;
    } t_out;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h37);
    endfunction

endpackage

@@ src/string_escape_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// string_escape_decoder_unit: quoted string escape decoder
// Byte stream in, decoded bytes and string status results out.
// ----------------------------------------------------------------------------
// One input byte is accepted per cycle while s_axis_tready is high. Each byte
// goes to an input register, is decoded from it into zero, one or two results
// once the output queue has room, and those are written into a four-entry
// output queue. The output port moves one result per cycle while m_axis_tready
// is high, so the sustained rate is one byte per cycle except where a byte ends
// a numeric escape and also yields a result of its own: such a byte yields two
// results. Input ready drops only when the queue has fewer than two free slots.
module string_escape_decoder_unit
    import sed_pkg::*;
#(
    parameter int OCTAL_DIGITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast
);

    localparam int         FIFO_DEPTH = 4;
    localparam int         FIFO_AW    = 2;
    localparam int         FIFO_CW    = 3;
    localparam logic [FIFO_CW-1:0] FIFO_ROOM = FIFO_CW'(FIFO_DEPTH - 2);

    typedef struct packed {
        t_res  res;
        logic  last;
    } t_entry;

    t_state              r_state, n_state;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    t_entry              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr, r_rd;
    logic [FIFO_CW-1:0]  r_cnt;
    t_out                w_out;
    logic                w_proc;
    logic                w_pop;
    logic [1:0]          w_push;
    t_kind               w_last_kind;

    sed_step #(
        .OCTAL_DIGITS(OCTAL_DIGITS)
    ) u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .o_state (n_state),
        .o_out   (w_out)
    );

    assign w_proc        = r_in_valid && (r_cnt <= FIFO_ROOM);
    assign w_push        = w_proc ? w_out.count : 2'd0;
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_proc;
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_fifo[r_rd].res.data;
    assign m_axis_tuser  = r_fifo[r_rd].res.kind;
    assign m_axis_tlast  = r_fifo[r_rd].last;
    assign w_last_kind   = (w_out.count == 2'd2) ? w_out.second.kind : w_out.first.kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= '{mode: MODE_IDLE, esc_val: 8'd0, oct_cnt: 2'd0};
            r_in_valid <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_proc) begin
                r_state <= n_state;
            end
            r_wr  <= r_wr + FIFO_AW'(w_push);
            r_rd  <= r_rd + FIFO_AW'(w_pop);
            r_cnt <= r_cnt + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
        end
    end

    // payload: input byte and queue entries
    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_push != 2'd0) begin
            r_fifo[r_wr] <= '{res: w_out.first, last: (w_push == 2'd1)};
        end
        if (w_push == 2'd2) begin
            r_fifo[r_wr + FIFO_AW'(1)] <= '{res: w_out.second, last: 1'b1};
        end
    end

    a_fifo_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue count exceeds depth");

    a_two_only_numeric : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_out.count == 2'd2) |->
        (r_state.mode == MODE_OCTAL || r_state.mode == MODE_HEX))
        else $error("two results outside a numeric escape");

    a_end_to_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_out.count != 2'd0 && w_last_kind != KIND_BYTE) |=>
        (r_state.mode == MODE_IDLE))
        else $error("string end or error did not return to idle");

    a_octal_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode == MODE_OCTAL) |-> (int'(r_state.oct_cnt) < OCTAL_DIGITS))
        else $error("octal digit count out of range");

    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == FIFO_CW'(FIFO_DEPTH)) |-> (w_push == 2'd0))
        else $error("push into full output queue");

endmodule

@@ src/sed_step.sv @@
// ----------------------------------------------------------------------------
// sed_step: next-state and result logic of the escape decoder
// Takes the current state and one byte, gives the next state and up to two
// results.
// ----------------------------------------------------------------------------
module sed_step
    import sed_pkg::*;
#(
    parameter int OCTAL_DIGITS = 3
) (
    input  t_state      i_state,
    input  logic [7:0]  i_byte,
    output t_state      o_state,
    output t_out        o_out
);

    localparam logic [2:0] OCT_MAX = 3'(OCTAL_DIGITS);

    logic        s_emit;
    t_res        s_res;
    t_mode       s_mode;
    logic [4:0]  w_hex;
    logic [1:0]  w_cnt_inc;

    assign w_hex     = hex_digit(i_byte);
    assign w_cnt_inc = i_state.oct_cnt + 2'd1;

    // plain string byte handling, shared by string mode and by the octal and hex modes when they end
    always_comb begin
        s_emit = 1'b1;
        s_mode = MODE_STRING;
        s_res  = '{data: i_byte, kind: KIND_BYTE};
        if (i_byte == CH_QUOTE) begin
            s_res  = '{data: CH_NUL, kind: KIND_CLOSED};
            s_mode = MODE_IDLE;
        end else if (i_byte == CH_NUL) begin
            s_res  = '{data: CH_NUL, kind: KIND_UNTERM};
            s_mode = MODE_IDLE;
        end else if (i_byte == CH_BSLASH) begin
            s_emit = 1'b0;
            s_mode = MODE_ESCAPE;
        end
    end

    always_comb begin
        o_state = i_state;
        o_out   = '{count: 2'd0, first: s_res, second: s_res};
        unique case (i_state.mode)
            MODE_STRING: begin
                o_state.mode = s_mode;
                o_out.count  = {1'b0, s_emit};
            end
            MODE_ESCAPE: begin
                o_state.mode = MODE_STRING;
                o_out.count  = 2'd1;
                case (i_byte) inside
                    CH_NUL: begin
                        o_out.first  = '{data: CH_NUL, kind: KIND_UNTERM};
                        o_state.mode = MODE_IDLE;
                    end
                    CH_LOW_B: o_out.first = '{data: CH_BS, kind: KIND_BYTE};
                    CH_LOW_F: o_out.first = '{data: CH_FF, kind: KIND_BYTE};
                    CH_LOW_N: o_out.first = '{data: CH_LF, kind: KIND_BYTE};
                    CH_LOW_R: o_out.first = '{data: CH_CR, kind: KIND_BYTE};
                    CH_LOW_T: o_out.first = '{data: CH_HT, kind: KIND_BYTE};
                    CH_BSLASH, CH_QUOTE: o_out.first = '{data: i_byte, kind: KIND_BYTE};
                    CH_LOW_X, CH_UP_X: begin
                        o_out.count     = 2'd0;
                        o_state.esc_val = 8'd0;
                        o_state.mode    = MODE_HEX;
                    end
                    default: begin
                        if (is_octal(i_byte)) begin
                            o_state.esc_val = {5'd0, i_byte[2:0]};
                            o_out.first     = '{data: {5'd0, i_byte[2:0]}, kind: KIND_BYTE};
                            if (3'd1 >= OCT_MAX) begin
                                o_state.oct_cnt = 2'd0;
                            end else begin
                                o_state.oct_cnt = 2'd1;
                                o_state.mode    = MODE_OCTAL;
                                o_out.count     = 2'd0;
                            end
                        end else begin
                            o_out.first  = '{data: i_byte, kind: KIND_UNKNOWN};
                            o_state.mode = MODE_IDLE;
                        end
                    end
                endcase
            end
            MODE_OCTAL: begin
                if (is_octal(i_byte)) begin
                    o_state.esc_val = {i_state.esc_val[4:0], i_byte[2:0]};
                    o_state.oct_cnt = w_cnt_inc;
                    o_out.first     = '{data: {i_state.esc_val[4:0], i_byte[2:0]},
                                        kind: KIND_BYTE};
                    if ({1'b0, w_cnt_inc} >= OCT_MAX) begin
                        o_state.oct_cnt = 2'd0;
                        o_state.mode    = MODE_STRING;
                        o_out.count     = 2'd1;
                    end
                end else begin
                    // flush the pending value, then treat the byte as text
                    o_out.first     = '{data: i_state.esc_val, kind: KIND_BYTE};
                    o_out.count     = s_emit ? 2'd2 : 2'd1;
                    o_state.oct_cnt = 2'd0;
                    o_state.mode    = s_mode;
                end
            end
            MODE_HEX: begin
                if (w_hex[4]) begin
                    o_state.esc_val = {i_state.esc_val[3:0], w_hex[3:0]};
                end else begin
                    o_out.first  = '{data: i_state.esc_val, kind: KIND_BYTE};
                    o_out.count  = s_emit ? 2'd2 : 2'd1;
                    o_state.mode = s_mode;
                end
            end
            default: begin
                // opening quote, whatever its value
                o_state.mode    = MODE_STRING;
                o_state.esc_val = 8'd0;
                o_state.oct_cnt = 2'd0;
            end
        endcase
    end

endmodule
